// ===== rtl/eihp_pkg.sv =====
`default_nettype none

package eihp_pkg;

  // One frame byte on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } frame_t;

  // One parse result, produced on the last byte of a frame.
  typedef struct packed {
    logic [2:0]  status;
    logic        is_ipv6;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] dest_port;
    logic [7:0]  dscp_field;
    logic [14:0] payload_offset;
  } result_t;

  // Status codes of a result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NOT_IP   = 3'd2;
  localparam logic [2:0] ST_BAD_IP   = 3'd3;
  localparam logic [2:0] ST_NOT_UDP  = 3'd4;
  localparam logic [2:0] ST_BAD_EXT  = 3'd5;
  localparam logic [2:0] ST_TOO_LONG = 3'd6;

  // Ether types.
  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  // IP protocol and next header numbers.
  localparam logic [7:0] PROTO_HOP   = 8'd0;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ROUTE = 8'd43;
  localparam logic [7:0] PROTO_FRAG  = 8'd44;
  localparam logic [7:0] PROTO_DST   = 8'd60;

  // Traffic class with the ECN bits cleared.
  localparam logic [7:0] DSCP_MASK = 8'hFC;

endpackage

`default_nettype wire

// ===== rtl/eihp_in_stage.sv =====
`default_nettype none

// Input register: holds one frame byte until the parser takes it.
module eihp_in_stage (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    frame_valid,
  output logic                   frame_stall,
  input  wire  eihp_pkg::frame_t frame,
  input  wire                    advance,
  output logic                   item_valid,
  output eihp_pkg::frame_t       item
);

  logic             valid_q;
  eihp_pkg::frame_t item_q;

  // The register frees up whenever its byte moves on in the same cycle.
  assign frame_stall = valid_q && !advance;
  assign item_valid  = valid_q;
  assign item        = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!frame_stall) begin
      valid_q <= frame_valid;
    end
    if (frame_valid && !frame_stall) begin
      item_q <= frame;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eihp_parse.sv =====
`default_nettype none

// Header parse state. Each step consumes one byte, updates the running
// offsets and captured fields, and on the last byte forms the result and
// clears itself for the next frame.
module eihp_parse #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     step,
  input  wire  eihp_pkg::frame_t  item,
  output eihp_pkg::result_t       result
);

  // Offsets can run past the frame length by one options header (2 KiB).
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 4096);

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_OPT  = 3'b010,
    PH_FRAG = 3'b100
  } phase_t;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      ether_type, ether_type_next;
  logic             vlan, vlan_next;
  logic [7:0]       next_proto, next_proto_next;
  logic [CNT_W-1:0] ext_start, ext_start_next;
  logic [CNT_W-1:0] udp_start, udp_start_next;
  logic [63:0]      addr_high, addr_high_next;
  logic [63:0]      addr_low, addr_low_next;
  logic [7:0]       dscp, dscp_next;
  logic [15:0]      port, port_next;
  logic [2:0]       parse_status, parse_status_next;
  logic             udp_known, udp_known_next;
  logic             walking, walking_next;
  phase_t           phase, phase_next;
  logic             too_long, too_long_next;

  always_comb begin
    logic [7:0]        din;
    logic [CNT_W-1:0]  off;
    logic [CNT_W-1:0]  ipst;
    logic [CNT_W-1:0]  rel;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  udp_eff;
    logic [CNT_W+15:0] offs_wide;
    logic [5:0]        ihl;
    logic [8:0]        opt_units;
    logic              ip_seen;
    logic              opt_hdr;
    logic              check_udp;
    logic [2:0]        fin;

    din               = item.data_byte;
    off               = byte_count;
    byte_count_next   = byte_count;
    ether_type_next   = ether_type;
    vlan_next         = vlan;
    next_proto_next   = next_proto;
    ext_start_next    = ext_start;
    udp_start_next    = udp_start;
    addr_high_next    = addr_high;
    addr_low_next     = addr_low;
    dscp_next         = dscp;
    port_next         = port;
    parse_status_next = parse_status;
    udp_known_next    = udp_known;
    walking_next      = walking;
    phase_next        = phase;
    too_long_next     = too_long;
    rel               = '0;
    ihl               = {din[3:0], 2'b00};
    opt_units         = {1'b0, din} + 9'd1;
    ip_seen           = 1'b0;
    opt_hdr           = 1'b0;

    if (byte_count == CNT_W'(MAX_FRAME_BYTES)) begin
      too_long_next = 1'b1;
    end else begin
      byte_count_next = byte_count + CNT_W'(1);

      // Ethernet type, and the inner type behind one VLAN tag.
      if (off == CNT_W'(12) || off == CNT_W'(13)) begin
        ether_type_next = {ether_type_next[7:0], din};
      end
      if (off == CNT_W'(13) && ether_type_next == eihp_pkg::ETH_VLAN) begin
        vlan_next = 1'b1;
      end
      if (vlan_next && (off == CNT_W'(16) || off == CNT_W'(17))) begin
        ether_type_next = {ether_type_next[7:0], din};
      end
      ipst = vlan_next ? CNT_W'(18) : CNT_W'(14);

      if (off >= ipst) begin
        rel = off - ipst;
        if (ether_type_next == eihp_pkg::ETH_IPV4) begin
          ip_seen = 1'b1;
          if (rel == CNT_W'(0)) begin
            if (din[7:4] != 4'd4 && parse_status_next == eihp_pkg::ST_OK) begin
              parse_status_next = eihp_pkg::ST_BAD_IP;
            end
            if (ihl < 6'd20) begin
              if (parse_status_next == eihp_pkg::ST_OK) begin
                parse_status_next = eihp_pkg::ST_BAD_IP;
              end
            end else begin
              udp_start_next = ipst + CNT_W'(ihl);
              udp_known_next = 1'b1;
            end
          end else if (rel == CNT_W'(1)) begin
            dscp_next = din & eihp_pkg::DSCP_MASK;
          end else if (rel == CNT_W'(9)) begin
            next_proto_next = din;
            if (din != eihp_pkg::PROTO_UDP && parse_status_next == eihp_pkg::ST_OK) begin
              parse_status_next = eihp_pkg::ST_NOT_UDP;
            end
          end else if (rel >= CNT_W'(16) && rel <= CNT_W'(19)) begin
            addr_low_next = {32'd0, addr_low_next[23:0], din};
          end
        end else if (ether_type_next == eihp_pkg::ETH_IPV6) begin
          ip_seen = 1'b1;
          if (rel == CNT_W'(0)) begin
            if (din[7:4] != 4'd6 && parse_status_next == eihp_pkg::ST_OK) begin
              parse_status_next = eihp_pkg::ST_BAD_IP;
            end
            dscp_next      = {din[3:0], 4'd0};
            ext_start_next = ipst + CNT_W'(40);
            walking_next   = 1'b1;
            phase_next     = PH_NONE;
          end else if (rel == CNT_W'(1)) begin
            dscp_next = (dscp_next | {4'd0, din[7:4]}) & eihp_pkg::DSCP_MASK;
          end else if (rel == CNT_W'(6)) begin
            next_proto_next = din;
          end else if (rel >= CNT_W'(24) && rel <= CNT_W'(31)) begin
            addr_high_next = {addr_high_next[55:0], din};
          end else if (rel >= CNT_W'(32) && rel <= CNT_W'(39)) begin
            addr_low_next = {addr_low_next[55:0], din};
          end

          // Extension header walk toward UDP.
          opt_hdr = next_proto_next == eihp_pkg::PROTO_HOP ||
                    next_proto_next == eihp_pkg::PROTO_DST ||
                    next_proto_next == eihp_pkg::PROTO_ROUTE;
          if (walking_next && parse_status_next == eihp_pkg::ST_OK && !udp_known_next) begin
            if (off == ext_start_next) begin
              if (next_proto_next == eihp_pkg::PROTO_UDP) begin
                udp_start_next = ext_start_next;
                udp_known_next = 1'b1;
              end else if (opt_hdr) begin
                phase_next      = PH_OPT;
                next_proto_next = din;
              end else if (next_proto_next == eihp_pkg::PROTO_FRAG) begin
                phase_next      = PH_FRAG;
                next_proto_next = din;
                ext_start_next  = ext_start_next + CNT_W'(8);
              end else begin
                parse_status_next = eihp_pkg::ST_BAD_EXT;
              end
            end else if (phase_next == PH_OPT && off == ext_start_next + CNT_W'(1)) begin
              ext_start_next = ext_start_next + CNT_W'({opt_units, 3'b000});
              phase_next     = PH_NONE;
            end
          end
        end

        if (ip_seen && udp_known_next &&
            (off == udp_start_next + CNT_W'(2) || off == udp_start_next + CNT_W'(3))) begin
          port_next = {port_next[7:0], din};
        end
      end
    end

    // End of frame status, from the state after this byte.
    len       = byte_count_next;
    ipst      = vlan_next ? CNT_W'(18) : CNT_W'(14);
    udp_eff   = udp_start_next;
    check_udp = 1'b0;
    fin       = eihp_pkg::ST_OK;
    opt_hdr   = next_proto_next == eihp_pkg::PROTO_HOP ||
                next_proto_next == eihp_pkg::PROTO_DST ||
                next_proto_next == eihp_pkg::PROTO_ROUTE;
    priority if (too_long_next) begin
      fin = eihp_pkg::ST_TOO_LONG;
    end else if (len < CNT_W'(14)) begin
      fin = eihp_pkg::ST_SHORT;
    end else if (vlan_next && len < CNT_W'(18)) begin
      fin = eihp_pkg::ST_SHORT;
    end else if (ether_type_next == eihp_pkg::ETH_IPV4) begin
      priority if (len < ipst + CNT_W'(20)) begin
        fin = eihp_pkg::ST_SHORT;
      end else if (parse_status_next != eihp_pkg::ST_OK) begin
        fin = parse_status_next;
      end else begin
        check_udp = 1'b1;
      end
    end else if (ether_type_next == eihp_pkg::ETH_IPV6) begin
      priority if (len < ipst + CNT_W'(40)) begin
        fin = eihp_pkg::ST_SHORT;
      end else if (parse_status_next != eihp_pkg::ST_OK) begin
        fin = parse_status_next;
      end else if (udp_known_next) begin
        check_udp = 1'b1;
      end else if (phase_next == PH_OPT) begin
        fin = eihp_pkg::ST_SHORT;
      end else if (phase_next == PH_FRAG && len < ext_start_next) begin
        fin = eihp_pkg::ST_SHORT;
      end else if (next_proto_next == eihp_pkg::PROTO_UDP) begin
        // UDP header starts at the end of the walk, at or past the frame end.
        udp_eff   = ext_start_next;
        check_udp = 1'b1;
      end else if (opt_hdr || next_proto_next == eihp_pkg::PROTO_FRAG) begin
        fin = eihp_pkg::ST_SHORT;
      end else begin
        fin = eihp_pkg::ST_BAD_EXT;
      end
    end else begin
      fin = eihp_pkg::ST_NOT_IP;
    end
    if (check_udp && len < udp_eff + CNT_W'(8)) begin
      fin = eihp_pkg::ST_SHORT;
    end

    offs_wide = {16'd0, udp_eff + CNT_W'(8)};
    result    = '0;
    result.status = fin;
    if (fin == eihp_pkg::ST_OK) begin
      result.is_ipv6        = ether_type_next == eihp_pkg::ETH_IPV6;
      result.dest_addr_high = result.is_ipv6 ? addr_high_next : 64'd0;
      result.dest_addr_low  = result.is_ipv6 ? addr_low_next
                                             : {32'd0, addr_low_next[31:0]};
      result.dest_port      = port_next;
      result.dscp_field     = dscp_next & eihp_pkg::DSCP_MASK;
      result.payload_offset = offs_wide[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_count   <= '0;
      ether_type   <= '0;
      vlan         <= 1'b0;
      next_proto   <= '0;
      ext_start    <= '0;
      udp_start    <= '0;
      addr_high    <= '0;
      addr_low     <= '0;
      dscp         <= '0;
      port         <= '0;
      parse_status <= eihp_pkg::ST_OK;
      udp_known    <= 1'b0;
      walking      <= 1'b0;
      phase        <= PH_NONE;
      too_long     <= 1'b0;
    end else if (step) begin
      byte_count   <= byte_count_next;
      ether_type   <= ether_type_next;
      vlan         <= vlan_next;
      next_proto   <= next_proto_next;
      ext_start    <= ext_start_next;
      udp_start    <= udp_start_next;
      addr_high    <= addr_high_next;
      addr_low     <= addr_low_next;
      dscp         <= dscp_next;
      port         <= port_next;
      parse_status <= parse_status_next;
      udp_known    <= udp_known_next;
      walking      <= walking_next;
      phase        <= phase_next;
      too_long     <= too_long_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eihp_out_stage.sv =====
`default_nettype none

// Result register: holds one result until the consumer takes it.
module eihp_out_stage (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     load,
  input  wire  eihp_pkg::result_t result_in,
  output logic                    ready,
  output logic                    result_valid,
  input  wire                     result_stall,
  output eihp_pkg::result_t       result
);

  logic              valid_q;
  eihp_pkg::result_t result_q;

  assign ready        = !valid_q || !result_stall;
  assign result_valid = valid_q;
  assign result       = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!result_stall) begin
      valid_q <= 1'b0;
    end
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/eth_ip_udp_header_parser.sv =====
`default_nettype none

// Channel   Handshake                    Payload    Transaction
// frame     frame_valid / frame_stall    frame_t    one frame byte
// result    result_valid / result_stall  result_t   one parse result per frame
//
// One byte is accepted per cycle while bytes keep coming and no result stall
// holds the input back. An accepted byte waits in the input register and is
// parsed in the cycle it moves on; the result of a frame is loaded into the
// result register as its last byte is parsed. Reset is synchronous and clears
// the parse state and both stages' valid flags. A result stall holds back a
// last byte only while an earlier result still waits; bytes behind it wait too.
module eth_ip_udp_header_parser #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     frame_valid,
  output logic                    frame_stall,
  input  wire  eihp_pkg::frame_t  frame,
  output logic                    result_valid,
  input  wire                     result_stall,
  output eihp_pkg::result_t       result
);

  logic              item_valid;
  eihp_pkg::frame_t  item;
  logic              advance;
  logic              out_ready;
  eihp_pkg::result_t parsed;

  // A byte in the input register is parsed now unless it ends a frame and
  // the result register cannot take the new result in this cycle.
  assign advance = item_valid && (!item.last_byte || out_ready);

  eihp_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .advance     (advance),
    .item_valid  (item_valid),
    .item        (item)
  );

  // All parsing for one byte happens in this stage, so the running offsets
  // are up to date for the very next byte.
  eihp_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (parsed)
  );

  // The result register loads only when a last byte is parsed.
  eihp_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && item.last_byte),
    .result_in    (parsed),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
